/* rtl/iirdf2_pkg.sv */
// ----------------------------------------------------------------------------
// iirdf2_pkg
// Widths, control word types and the sequencer program of the direct form II
// IIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package iirdf2_pkg;

    localparam int MAX_ORDER_DEF = 8;

    localparam int ORD_W     = 4;
    localparam int IDX_W     = 4;
    localparam int SMP_W     = 24;
    localparam int COEF_W    = 24;
    localparam int DLY_W     = 32;
    localparam int PROD_W    = COEF_W + DLY_W;
    localparam int ACC_W     = 64;
    localparam int FRAC_BITS = 20;

    localparam logic [DLY_W-1:0] W_MAX = {1'b0, {(DLY_W-1){1'b1}}};
    localparam logic [DLY_W-1:0] W_MIN = {1'b1, {(DLY_W-1){1'b0}}};
    localparam logic [SMP_W-1:0] Y_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic [SMP_W-1:0] Y_MIN = {1'b1, {(SMP_W-1){1'b0}}};

    localparam logic FUNC_FILTER = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;
    localparam logic SET_NUM     = 1'b0;
    localparam logic SET_DEN     = 1'b1;

    typedef logic [2:0] t_pc;

    localparam t_pc PC_START  = 3'd0;
    localparam t_pc PC_TAP_A  = 3'd1;
    localparam t_pc PC_TAP_B  = 3'd2;
    localparam t_pc PC_W0     = 3'd3;
    localparam t_pc PC_MUL_B0 = 3'd4;
    localparam t_pc PC_SETTLE = 3'd5;
    localparam t_pc PC_OUT    = 3'd6;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_START,
        C_LOOP,
        C_OUT
    } t_cond;

    typedef enum logic [1:0] {
        M_NONE,
        M_AD,
        M_BD,
        M_BW
    } t_mul;

    typedef enum logic [1:0] {
        DW_NONE,
        DW_TAP,
        DW_W0
    } t_dwr;

    typedef struct packed {
        t_cond cond;
        t_pc   target;
        logic  rd_en;
        logic  dec_k;
        t_mul  mul;
        t_dwr  dwr;
        logic  w0_lat;
    } t_uword;

    // Sequencer program. One pass per sample: two steps per tap share the
    // multiplier between the denominator and numerator products.
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '0;
        case (pc)
            PC_START: begin
                w.cond   = C_START;
                w.target = PC_W0;
                w.rd_en  = 1'b1;
            end
            PC_TAP_A: begin
                w.cond = C_NEXT;
                w.mul  = M_AD;
                w.dwr  = DW_TAP;
            end
            PC_TAP_B: begin
                w.cond   = C_LOOP;
                w.target = PC_TAP_A;
                w.rd_en  = 1'b1;
                w.dec_k  = 1'b1;
                w.mul    = M_BD;
            end
            PC_W0: begin
                w.cond   = C_NEXT;
                w.w0_lat = 1'b1;
            end
            PC_MUL_B0: begin
                w.cond = C_NEXT;
                w.mul  = M_BW;
                w.dwr  = DW_W0;
            end
            PC_SETTLE: begin
                w.cond = C_NEXT;
            end
            PC_OUT: begin
                w.cond   = C_OUT;
                w.target = PC_START;
            end
            default: begin
                w.cond   = C_JUMP;
                w.target = PC_START;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/iirdf2_if.sv */
// ----------------------------------------------------------------------------
// iirdf2 channel interfaces
// Valid/ready channels for input items and result items of the filter.
// ----------------------------------------------------------------------------
`default_nettype none

interface iirdf2_in_if import iirdf2_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic signed [SMP_W-1:0] sample_in;
    logic                    clear_history;
    logic                    coef_set;
    logic [IDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;

    modport source (
        output valid, func, sample_in, clear_history, coef_set, coef_index, coef_value,
        input  ready
    );
    modport sink (
        input  valid, func, sample_in, clear_history, coef_set, coef_index, coef_value,
        output ready
    );
endinterface

interface iirdf2_out_if import iirdf2_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] filtered_out;
    logic                    saturated;

    modport source (
        output valid, filtered_out, saturated,
        input  ready
    );
    modport sink (
        input  valid, filtered_out, saturated,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/iir_direct_form_two_top.sv */
// ----------------------------------------------------------------------------
// iir_direct_form_two_top
// Direct form II IIR filter of programmable order with one shared
// multiply-accumulate unit driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  i_in      in    valid / ready    func, sample_in, clear_history, coef_*
//  o_out     out   valid / ready    filtered_out, saturated
//  i_cfg     in    i_cfg_we         i_cfg_wdata (filter order)
//
//  A coefficient write completes as it is accepted. A sample holds off the
//  next item from acceptance until its pass ends; the single 24x32
//  multiplier serves one product per cycle, two per tap.
//  Reset clears the stores through per-entry valid bits, with no clearing pass.
//  A full output register stalls the sequencer at its last step only.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_direct_form_two_top import iirdf2_pkg::*; #(
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    iirdf2_in_if.sink             i_in,
    iirdf2_out_if.source          o_out,
    input  wire logic             i_cfg_we,
    input  wire logic [ORD_W-1:0] i_cfg_wdata
);

    localparam int DEPTH = MAX_ORDER + 1;
    localparam int KW    = $clog2(DEPTH);

    t_pc    r_pc, n_pc;
    t_uword uw;

    logic [KW-1:0]    r_k, n_k;
    logic [ORD_W-1:0] r_order;
    logic [KW-1:0]    eff_order;

    logic in_acc, smp_go, cof_go, clr_now, idx_ok;
    logic rd_go, d_rd_go, out_load;
    logic [KW-1:0] d_raddr, c_raddr, c_waddr;

    // Stores and their valid bits.
    logic [DLY_W-1:0]  mem_d [DEPTH];
    logic [COEF_W-1:0] mem_a [DEPTH];
    logic [COEF_W-1:0] mem_b [DEPTH];
    logic [DEPTH-1:0]  r_d_vld, r_a_vld, r_b_vld;

    logic [DLY_W-1:0]  r_d_rd;
    logic [COEF_W-1:0] r_a_rd, r_b_rd;
    logic              r_d_v, r_a_v, r_b_v;
    logic [DLY_W-1:0]  d_eff;
    logic [COEF_W-1:0] a_eff, b_eff;

    logic              d_we;
    logic [KW-1:0]     d_waddr;
    logic [DLY_W-1:0]  d_wdata;

    logic signed [COEF_W-1:0] mul_c;
    logic signed [DLY_W-1:0]  mul_d;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] r_prod;
    t_mul                     r_ptag;
    logic [ACC_W-1:0]         prod_x;
    logic [ACC_W-1:0]         r_acc_a, r_acc_b;

    logic             w0_fits, y_fits;
    logic [DLY_W-1:0] w0_val;
    logic [SMP_W-1:0] y_val;
    logic [DLY_W-1:0] r_w0;
    logic             r_sat;

    logic             r_out_vld;
    logic [SMP_W-1:0] r_y;
    logic             r_sat_out;

    assign uw = ucode(r_pc);

    assign i_in.ready = (r_pc == PC_START);
    assign in_acc     = i_in.valid & i_in.ready;
    assign smp_go     = in_acc & (i_in.func == FUNC_FILTER);
    assign cof_go     = in_acc & (i_in.func == FUNC_COEF);
    assign clr_now    = smp_go & i_in.clear_history;
    assign idx_ok     = {{(32-IDX_W){1'b0}}, i_in.coef_index} <= 32'(MAX_ORDER);
    assign c_waddr    = KW'(i_in.coef_index);

    // An order above the built maximum acts as the maximum.
    always_comb begin
        if ({{(32-ORD_W){1'b0}}, r_order} > 32'(MAX_ORDER)) begin
            eff_order = KW'(MAX_ORDER);
        end else begin
            eff_order = KW'(r_order);
        end
    end

    assign out_load = (uw.cond == C_OUT) && (!r_out_vld || o_out.ready);

    always_comb begin
        if (uw.cond == C_START && smp_go) begin
            n_k = eff_order;
        end else if (uw.dec_k) begin
            n_k = r_k - KW'(1);
        end else begin
            n_k = r_k;
        end
    end

    always_comb begin
        case (uw.cond)
            C_NEXT:  n_pc = r_pc + t_pc'(1);
            C_JUMP:  n_pc = uw.target;
            C_START: begin
                if (smp_go) begin
                    n_pc = (eff_order == '0) ? uw.target : r_pc + t_pc'(1);
                end else begin
                    n_pc = r_pc;
                end
            end
            C_LOOP:  n_pc = (n_k != '0) ? uw.target : r_pc + t_pc'(1);
            C_OUT:   n_pc = out_load ? uw.target : r_pc;
            default: n_pc = PC_START;
        endcase
    end

    // Reads fetch the tap below the counter and the coefficients at it into
    // registers, ahead of the multiplier steps that use them.
    assign rd_go   = uw.rd_en && (uw.cond != C_START || smp_go);
    assign d_rd_go = rd_go && (n_k != '0);
    assign d_raddr = n_k - KW'(1);
    assign c_raddr = n_k;

    assign d_eff = r_d_v ? r_d_rd : '0;
    assign a_eff = r_a_v ? r_a_rd : '0;
    assign b_eff = r_b_v ? r_b_rd : '0;

    always_comb begin
        d_we    = 1'b0;
        d_waddr = r_k;
        d_wdata = d_eff;
        case (uw.dwr)
            DW_TAP: d_we = 1'b1;
            DW_W0: begin
                d_we    = 1'b1;
                d_waddr = '0;
                d_wdata = r_w0;
            end
            default: d_we = 1'b0;
        endcase
    end

    // Store data and read ports.
    always_ff @(posedge i_clk) begin
        if (d_we) begin
            mem_d[d_waddr] <= d_wdata;
        end
        if (cof_go && idx_ok && i_in.coef_set == SET_NUM) begin
            mem_b[c_waddr] <= i_in.coef_value;
        end
        if (cof_go && idx_ok && i_in.coef_set == SET_DEN) begin
            mem_a[c_waddr] <= i_in.coef_value;
        end
        if (d_rd_go) begin
            r_d_rd <= mem_d[d_raddr];
            r_d_v  <= r_d_vld[d_raddr] & ~clr_now;
        end
        if (rd_go) begin
            r_a_rd <= mem_a[c_raddr];
            r_a_v  <= r_a_vld[c_raddr];
            r_b_rd <= mem_b[c_raddr];
            r_b_v  <= r_b_vld[c_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= '0;
            r_a_vld <= '0;
            r_b_vld <= '0;
        end else begin
            if (clr_now) begin
                r_d_vld <= '0;
            end else if (d_we) begin
                r_d_vld[d_waddr] <= 1'b1;
            end
            if (cof_go && idx_ok && i_in.coef_set == SET_NUM) begin
                r_b_vld[c_waddr] <= 1'b1;
            end
            if (cof_go && idx_ok && i_in.coef_set == SET_DEN) begin
                r_a_vld[c_waddr] <= 1'b1;
            end
        end
    end

    // Shared multiplier; the product is registered and accumulated in the cycle after.
    assign mul_c  = (uw.mul == M_AD) ? a_eff : b_eff;
    assign mul_d  = (uw.mul == M_BW) ? r_w0 : d_eff;
    assign mul_p  = mul_c * mul_d;
    assign prod_x = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (smp_go) begin
            r_acc_a <= {{(ACC_W-SMP_W-FRAC_BITS){i_in.sample_in[SMP_W-1]}},
                        i_in.sample_in, {FRAC_BITS{1'b0}}};
            r_acc_b <= '0;
        end else begin
            case (r_ptag)
                M_AD:        r_acc_a <= r_acc_a - prod_x;
                M_BD, M_BW:  r_acc_b <= r_acc_b + prod_x;
                default:     r_acc_b <= r_acc_b;
            endcase
        end
    end

    // Shift right by the fraction bits is a slice; clip where the upper bits
    // are not all copies of the sign.
    assign w0_fits = (&r_acc_a[ACC_W-1:FRAC_BITS+DLY_W-1]) |
                     ~(|r_acc_a[ACC_W-1:FRAC_BITS+DLY_W-1]);
    assign w0_val  = w0_fits ? r_acc_a[FRAC_BITS+DLY_W-1:FRAC_BITS] :
                     (r_acc_a[ACC_W-1] ? W_MIN : W_MAX);
    assign y_fits  = (&r_acc_b[ACC_W-1:FRAC_BITS+SMP_W-1]) |
                     ~(|r_acc_b[ACC_W-1:FRAC_BITS+SMP_W-1]);
    assign y_val   = y_fits ? r_acc_b[FRAC_BITS+SMP_W-1:FRAC_BITS] :
                     (r_acc_b[ACC_W-1] ? Y_MIN : Y_MAX);

    always_ff @(posedge i_clk) begin
        if (uw.w0_lat) begin
            r_w0  <= w0_val;
            r_sat <= ~w0_fits;
        end
        if (out_load) begin
            r_y       <= y_val;
            r_sat_out <= r_sat | ~y_fits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= PC_START;
            r_k       <= '0;
            r_order   <= ORD_W'(1);
            r_ptag    <= M_NONE;
            r_out_vld <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_k    <= n_k;
            r_ptag <= uw.mul;
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.filtered_out = r_y;
    assign o_out.saturated    = r_sat_out;

endmodule

`default_nettype wire

/* rtl/iirdf2_chk.sv */
// ----------------------------------------------------------------------------
// iirdf2_chk
// Port-level checks of the filter: result items against samples taken, the
// input busy rule and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module iirdf2_chk import iirdf2_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_in_func,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [SMP_W-1:0] i_filtered_out,
    input wire logic             i_saturated
);

    logic       smp_acc, out_acc;
    logic [1:0] r_pend;

    assign smp_acc = i_in_valid && i_in_ready && (i_in_func == FUNC_FILTER);
    assign out_acc = i_out_valid && i_out_ready;

    // Samples taken whose result item has not yet been delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, smp_acc} - {1'b0, out_acc};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
        i_out_valid && $stable(i_filtered_out) && $stable(i_saturated))
        else $error("result item changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_pend != 2'd0)
        else $error("result item without a sample");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two samples in flight");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        smp_acc |=> !i_in_ready)
        else $error("input taken while a sample is in work");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result item valid after reset");

endmodule

bind iir_direct_form_two_top iirdf2_chk u_iirdf2_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_func      (i_in.func),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_filtered_out (o_out.filtered_out),
    .i_saturated    (o_out.saturated)
);

`default_nettype wire
